// ----- hdl/olid_pkg.sv -----
// ---------------------------------------------------------------------------
// olid_pkg
// shared types and codes for the ordered list block: request and result
// payloads, request and status codes, per-cell control
// ---------------------------------------------------------------------------
package olid_pkg;

	localparam int DATA_W      = 32;
	localparam int MAX_RESULTS = 16;

	typedef enum logic [2:0] {
		REQ_APPEND    = 3'd0,
		REQ_DEL_FIRST = 3'd1,
		REQ_DEL_LAST  = 3'd2,
		REQ_DEL_VALUE = 3'd3,
		REQ_READ_ALL  = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] operand_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] entry_value;
		logic                     last_of_run;
	} rsp_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic wr;        // take the operand (append at tail)
		logic shift;     // take the neighbour's entry (close a gap)
		logic cmp;       // compare entry with the operand
		logic rd_load;   // copy entry into the read-out chain
		logic rd_shift;  // take the neighbour's read-out word
	} cell_ctl_t;

endpackage

// ----- hdl/olid_stream_if.sv -----
// ---------------------------------------------------------------------------
// olid_stream_if
// valid/ready channel carrying one payload item per handshake
// ---------------------------------------------------------------------------
interface olid_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/olid_cell.sv -----
// ---------------------------------------------------------------------------
// olid_cell
// one slot of the list: entry register, match flag and read-out word
// ---------------------------------------------------------------------------
module olid_cell
	import olid_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     occupied,
	input  logic signed [DATA_W-1:0] operand,
	input  logic signed [DATA_W-1:0] next_val,
	input  logic signed [DATA_W-1:0] next_rd,
	output logic signed [DATA_W-1:0] val,
	output logic signed [DATA_W-1:0] rd,
	output logic                     match
);

	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] rd_q;
	logic                     match_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			val_q <= operand;
		end else if (ctl.shift) begin
			val_q <= next_val;
		end
		if (ctl.cmp) begin
			match_q <= occupied && (val_q == operand);
		end
		if (ctl.rd_load) begin
			rd_q <= val_q;
		end else if (ctl.rd_shift) begin
			rd_q <= next_rd;
		end
	end

	assign val   = val_q;
	assign rd    = rd_q;
	assign match = match_q;

endmodule

// ----- hdl/ordered_list_insert_delete.sv -----
// ---------------------------------------------------------------------------
// ordered_list_insert_delete
// bounded ordered list of signed 32-bit entries held in a row of cells;
// append, delete first / last / by value, and read-all streaming
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                  | item
//  --------+-----+------------------------------------------+----------------
//  req     | in  | req_type[2:0], operand_value[31:0]       | one request
//  rsp     | out | status[1:0], entry_value[31:0], last_of_run | one result
//
// append, delete first, delete last and unknown codes: one item per cycle
// delete value: cells compare in parallel, then in S_DELV the gap closes
// read all: load the read-out chain, then one entry emitted per cycle while
//   the output is free (at most MAX_RESULTS), the chain shifting towards cell 0
// a waiting result in the output register holds off the next request
// arst_n clears sequencer, fill count and output valid; cell data has no reset
// ---------------------------------------------------------------------------
module ordered_list_insert_delete
	import olid_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	olid_stream_if.sink          req,
	olid_stream_if.source        rsp
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int RLW = $clog2(MAX_RESULTS + 1);
	localparam int WW  = (CW > RLW) ? CW : RLW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DELV,
		S_READ
	} state_t;

	state_t           state_q, state_nxt;
	logic [CW-1:0]    count_q, count_nxt;
	logic [RLW-1:0]   rd_left_q, rd_left_nxt;
	logic             out_valid_q;
	rsp_t             out_q, out_nxt;
	logic             out_load;
	logic             out_free;
	logic             in_fire;

	// cell row
	cell_ctl_t                ctl      [CAPACITY];
	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic signed [DATA_W-1:0] cell_rd  [CAPACITY];
	logic [CAPACITY-1:0]      match;
	logic [CAPACITY-1:0]      occupied;
	logic [CAPACITY-1:0]      after_hit;
	logic                     found;
	logic [WW-1:0]            count_w;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [DATA_W-1:0] nv;
			logic signed [DATA_W-1:0] nr;
			if (g == CAPACITY - 1) begin : g_end
				assign nv = '0;
				assign nr = '0;
			end else begin : g_mid
				assign nv = cell_val[g+1];
				assign nr = cell_rd[g+1];
			end
			assign occupied[g] = (CW'(g) < count_q);
			olid_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[g]),
				.occupied (occupied[g]),
				.operand  (req.data.operand_value),
				.next_val (nv),
				.next_rd  (nr),
				.val      (cell_val[g]),
				.rd       (cell_rd[g]),
				.match    (match[g])
			);
		end
	endgenerate

	// every cell at or after the first hit moves one place towards the head
	always_comb begin
		after_hit = match;
		for (int d = 1; d < CAPACITY; d = d * 2) begin
			after_hit = after_hit | (after_hit << d);
		end
	end
	assign found = |match;

	assign count_w  = WW'(count_q);
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign in_fire  = req.valid && req.ready;

	// sequencer: cell controls, next result, next count
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i] = '0;
		end
		state_nxt   = state_q;
		count_nxt   = count_q;
		rd_left_nxt = rd_left_q;
		out_load    = 1'b0;
		out_nxt.status      = ST_OK;
		out_nxt.entry_value = '0;
		out_nxt.last_of_run = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (req.data.req_type)
						REQ_APPEND: begin
							out_load = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								out_nxt.status = ST_FULL;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									ctl[i].wr = (CW'(i) == count_q);
								end
								count_nxt = count_q + CW'(1);
							end
						end
						REQ_DEL_FIRST: begin
							out_load = 1'b1;
							if (count_q == '0) begin
								out_nxt.status = ST_EMPTY;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									ctl[i].shift = 1'b1;
								end
								count_nxt = count_q - CW'(1);
							end
						end
						REQ_DEL_LAST: begin
							out_load = 1'b1;
							if (count_q == '0) begin
								out_nxt.status = ST_EMPTY;
							end else begin
								count_nxt = count_q - CW'(1);
							end
						end
						REQ_DEL_VALUE: begin
							if (count_q == '0) begin
								out_load = 1'b1;
								out_nxt.status = ST_EMPTY;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									ctl[i].cmp = 1'b1;
								end
								state_nxt = S_DELV;
							end
						end
						REQ_READ_ALL: begin
							if (count_q == '0) begin
								out_load = 1'b1;
								out_nxt.status = ST_EMPTY;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									ctl[i].rd_load = 1'b1;
								end
								if (count_w > WW'(MAX_RESULTS)) begin
									rd_left_nxt = RLW'(MAX_RESULTS);
								end else begin
									rd_left_nxt = RLW'(count_w);
								end
								state_nxt = S_READ;
							end
						end
						default: begin
							// unknown code: plain ok result, list untouched
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_DELV: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = S_IDLE;
					if (found) begin
						for (int i = 0; i < CAPACITY; i++) begin
							ctl[i].shift = after_hit[i];
						end
						count_nxt = count_q - CW'(1);
					end else begin
						out_nxt.status = ST_NOTFOUND;
					end
				end
			end
			S_READ: begin
				if (out_free) begin
					out_load            = 1'b1;
					out_nxt.entry_value = cell_rd[0];
					out_nxt.last_of_run = (rd_left_q == RLW'(1));
					for (int i = 0; i < CAPACITY; i++) begin
						ctl[i].rd_shift = 1'b1;
					end
					rd_left_nxt = rd_left_q - RLW'(1);
					if (rd_left_q == RLW'(1)) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			count_q   <= count_nxt;
			rd_left_q <= rd_left_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the ordered list block: a short table of directed
// requests, then random request mixes that drive the list towards full and
// empty; every result is checked against its fixed row or a shadow copy of the list
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import olid_pkg::*;

	localparam int LIST_CAP     = 16;
	localparam int RANDOM_ITEMS = 95;
	localparam int TAIL_CYCLES  = 20;

	// request codes that the block does not decode
	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum {MOOD_GROW, MOOD_SHRINK, MOOD_MIXED} mood_t;
	typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_RHYTHM} stall_mode_t;

	// one row of the directed table; fixed rows carry their own result
	typedef struct {
		logic [2:0]               code;
		logic signed [DATA_W-1:0] operand;
		int                       reps;
		bit                       fixed;
		rsp_t                     want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	olid_stream_if #(.payload_t(req_t)) req_if ();
	olid_stream_if #(.payload_t(rsp_t)) rsp_if ();

	ordered_list_insert_delete #(
		.CAPACITY(LIST_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// shadow copy of the list, head at index 0
	logic signed [DATA_W-1:0] shadow_list[$];
	// results of the latest request, and results still owed by the block
	rsp_t     list_rsp[$];
	rsp_t     rsp_due[$];
	dir_row_t dir_rows[$];

	int err_count  = 0;
	int burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic rsp_t make_rsp(input logic [1:0] st,
			input logic signed [DATA_W-1:0] v, input logic last);
		rsp_t r;
		r.status      = st;
		r.entry_value = v;
		r.last_of_run = last;
		return r;
	endfunction

	// applies one request to the shadow list and lists the results it causes
	function automatic void apply_list_request(input req_t r);
		int hit;
		int n;
		list_rsp.delete();
		hit = -1;
		case (r.req_type)
			REQ_APPEND: begin
				if (shadow_list.size() >= LIST_CAP) begin
					list_rsp.push_back(make_rsp(ST_FULL, '0, 1'b1));
				end else begin
					shadow_list.push_back(r.operand_value);
					list_rsp.push_back(make_rsp(ST_OK, '0, 1'b1));
				end
			end
			REQ_DEL_FIRST: begin
				if (shadow_list.size() == 0) begin
					list_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
				end else begin
					void'(shadow_list.pop_front());
					list_rsp.push_back(make_rsp(ST_OK, '0, 1'b1));
				end
			end
			REQ_DEL_LAST: begin
				if (shadow_list.size() == 0) begin
					list_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
				end else begin
					void'(shadow_list.pop_back());
					list_rsp.push_back(make_rsp(ST_OK, '0, 1'b1));
				end
			end
			REQ_DEL_VALUE: begin
				if (shadow_list.size() == 0) begin
					list_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
				end else begin
					// first match from the head wins
					for (int i = 0; i < shadow_list.size() && hit < 0; i++)
						if (shadow_list[i] == r.operand_value)
							hit = i;
					if (hit < 0) begin
						list_rsp.push_back(make_rsp(ST_NOTFOUND, '0, 1'b1));
					end else begin
						shadow_list.delete(hit);
						list_rsp.push_back(make_rsp(ST_OK, '0, 1'b1));
					end
				end
			end
			REQ_READ_ALL: begin
				if (shadow_list.size() == 0) begin
					list_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
				end else begin
					n = (shadow_list.size() > MAX_RESULTS) ? MAX_RESULTS : shadow_list.size();
					for (int i = 0; i < n; i++)
						list_rsp.push_back(make_rsp(ST_OK, shadow_list[i], i == n - 1));
				end
			end
			default: begin
				list_rsp.push_back(make_rsp(ST_OK, '0, 1'b1));
			end
		endcase
	endfunction

	// request mix per mood: append, delete value, delete first, delete last, read all, spare codes
	function automatic logic [2:0] pick_code(input mood_t mood);
		int roll;
		int t_app;
		int t_dv;
		int t_df;
		int t_dl;
		int t_rd;
		case (mood)
			MOOD_GROW: begin
				t_app = 60; t_dv = 75; t_df = 83; t_dl = 90; t_rd = 98;
			end
			MOOD_SHRINK: begin
				t_app = 15; t_dv = 50; t_df = 70; t_dl = 90; t_rd = 98;
			end
			default: begin
				t_app = 35; t_dv = 60; t_df = 72; t_dl = 84; t_rd = 97;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < t_app)
			return REQ_APPEND;
		else if (roll < t_dv)
			return REQ_DEL_VALUE;
		else if (roll < t_df)
			return REQ_DEL_FIRST;
		else if (roll < t_dl)
			return REQ_DEL_LAST;
		else if (roll < t_rd)
			return REQ_READ_ALL;
		return 3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
	endfunction

	// operands: small values collide often, list entries make deletes hit,
	// full-width values exercise every bit
	function automatic logic signed [DATA_W-1:0] pick_operand(input logic [2:0] code);
		int roll;
		roll = $urandom_range(0, 99);
		if (code == REQ_DEL_VALUE && shadow_list.size() != 0 && roll < 45)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		if (roll < 75)
			return $signed($urandom_range(0, 8)) - 4;
		if (roll < 82)
			return (roll[0]) ? VAL_MAX : VAL_MIN;
		return $urandom;
	endfunction

	task automatic add_row(input logic [2:0] code, input logic signed [DATA_W-1:0] operand,
			input int reps, input bit fixed, input logic [1:0] st,
			input logic signed [DATA_W-1:0] v, input logic last);
		dir_row_t row;
		row.code    = code;
		row.operand = operand;
		row.reps    = reps;
		row.fixed   = fixed;
		row.want    = make_rsp(st, v, last);
		dir_rows.push_back(row);
	endtask

	// sends one item in bursts with random gaps, then books its results
	task automatic issue_request(input req_t r, input bit fixed, input rsp_t want);
		int gap;
		if (burst_left == 0) begin
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 32)
			                                         : $urandom_range(1, 8);
			gap = $urandom_range(1, 6);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		apply_list_request(r);
		if (fixed)
			rsp_due.push_back(want);
		else
			foreach (list_rsp[i]) rsp_due.push_back(list_rsp[i]);
	endtask

	// holds the sender off until the block owes nothing
	task automatic wait_rsp_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (rsp_due.size() != 0);
		burst_left = 0;
	endtask

	initial begin : stimulus
		req_t  r;
		mood_t mood;
		int    phase_len;
		int    issued;
		bit    paused;

		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;

		// directed table: fixed rows carry a result that is plain to see,
		// the rest go through the shadow list
		add_row(REQ_READ_ALL,  '0,      1,  1'b1, ST_EMPTY,    '0, 1'b1); // read of empty list
		add_row(REQ_DEL_FIRST, '0,      1,  1'b1, ST_EMPTY,    '0, 1'b1);
		add_row(REQ_DEL_LAST,  '0,      1,  1'b1, ST_EMPTY,    '0, 1'b1);
		add_row(REQ_DEL_VALUE, '0,      1,  1'b1, ST_EMPTY,    '0, 1'b1);
		add_row(REQ_SPARE_5,   VAL_MAX, 1,  1'b1, ST_OK,       '0, 1'b1); // undecoded code
		add_row(REQ_APPEND,    VAL_MAX, 1,  1'b1, ST_OK,       '0, 1'b1);
		add_row(REQ_APPEND,    VAL_MIN, 1,  1'b1, ST_OK,       '0, 1'b1);
		add_row(REQ_APPEND,    -1,      1,  1'b1, ST_OK,       '0, 1'b1);
		add_row(REQ_DEL_VALUE, '0,      1,  1'b1, ST_NOTFOUND, '0, 1'b1); // value absent
		add_row(REQ_READ_ALL,  '0,      1,  1'b0, ST_OK,       '0, 1'b0);
		add_row(REQ_DEL_VALUE, VAL_MIN, 1,  1'b0, ST_OK,       '0, 1'b0); // middle entry
		add_row(REQ_APPEND,    -3,      14, 1'b0, ST_OK,       '0, 1'b0); // fill, -1 twice
		add_row(REQ_APPEND,    VAL_MIN, 1,  1'b1, ST_FULL,     '0, 1'b1); // list full
		add_row(REQ_READ_ALL,  '0,      1,  1'b0, ST_OK,       '0, 1'b0); // longest run
		add_row(REQ_DEL_VALUE, -1,      1,  1'b0, ST_OK,       '0, 1'b0); // first of two
		add_row(REQ_DEL_VALUE, VAL_MAX, 1,  1'b0, ST_OK,       '0, 1'b0); // head entry
		add_row(REQ_DEL_FIRST, '0,      1,  1'b0, ST_OK,       '0, 1'b0);
		add_row(REQ_DEL_LAST,  '0,      1,  1'b0, ST_OK,       '0, 1'b0);
		add_row(REQ_READ_ALL,  '0,      1,  1'b0, ST_OK,       '0, 1'b0);
		add_row(REQ_SPARE_7,   VAL_MIN, 1,  1'b1, ST_OK,       '0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			for (int j = 0; j < dir_rows[k].reps; j++) begin
				r.req_type      = dir_rows[k].code;
				r.operand_value = dir_rows[k].operand + j;
				issue_request(r, dir_rows[k].fixed, dir_rows[k].want);
			end
		end

		// random part: phases that lean towards growing, shrinking or neither,
		// so the list keeps reaching full and empty
		issued = 0;
		paused = 1'b0;
		while (issued < RANDOM_ITEMS) begin
			mood      = mood_t'($urandom_range(0, 2));
			phase_len = $urandom_range(6, 20);
			repeat (phase_len) begin
				r.req_type      = pick_code(mood);
				r.operand_value = pick_operand(r.req_type);
				issue_request(r, 1'b0, make_rsp(ST_OK, '0, 1'b0));
				if (r.req_type <= REQ_READ_ALL)
					issued++;
			end
			// once, mid-way, let the block empty its output before going on
			if (!paused && issued >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_rsp_drained();
			end
		end

		wait_rsp_drained();
		// look out for stray results after the last one owed
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// receiver: spells of steady ready, coin-toss, heavy stall and a fixed rhythm
	initial begin : rsp_stall
		stall_mode_t mode;
		int          span;
		int          tick;
		tick = 0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(8, 40);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
					STALL_NONE:  rsp_if.ready <= 1'b1;
					STALL_COIN:  rsp_if.ready <= 1'($urandom_range(0, 1));
					STALL_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
					default:     rsp_if.ready <= ((tick % 5) < 3);
				endcase
			end
		end
	end

	// every accepted result against the oldest one owed
	always @(posedge clk) begin : rsp_check
		rsp_t got;
		rsp_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			got = rsp_if.data;
			if (rsp_due.size() == 0) begin
				err_count++;
				$display("%0t: result expected none got status %0d entry %0d last %0d",
				         $time, got.status, got.entry_value, got.last_of_run);
			end else begin
				want = rsp_due.pop_front();
				if (got.status !== want.status) begin
					err_count++;
					$display("%0t: status expected %0d got %0d",
					         $time, want.status, got.status);
				end
				if (got.entry_value !== want.entry_value) begin
					err_count++;
					$display("%0t: entry_value expected %0d got %0d",
					         $time, want.entry_value, got.entry_value);
				end
				if (got.last_of_run !== want.last_of_run) begin
					err_count++;
					$display("%0t: last_of_run expected %0d got %0d",
					         $time, want.last_of_run, got.last_of_run);
				end
			end
		end
	end

endmodule
